FILE: rtl/sha_pkg.sv
// Shared types, round constants and SHA-256 helper functions for the byte stream hasher.
package sha_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned LEN_BYTE    = 56;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [63:0] BLOCK_BITS  = 64'd512;

   // Input transfer: one optional message byte and an end marker
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } sha_req_type;

   // Output transfer: one digest word
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_COMP,
      ST_ADD,
      ST_OUT
   } sha_state_type;

   // How the sixteen schedule words of the block being compressed are sourced
   typedef enum logic [1:0] {
      BLK_NORMAL,     // all words from the block memory
      BLK_PAD_LEN,    // data, pad byte, zeros and the length
      BLK_PAD_ONLY,   // data, pad byte and zeros; length follows in an extra block
      BLK_LEN_ONLY    // zeros and the length
   } sha_mode_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (WORD_BITS - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] a);
      big_sigma0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] e);
      big_sigma1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] w);
      small_sigma0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] w);
      small_sigma1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
   endfunction

   // Initial hash values
   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] h;
      unique case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         3'd7: h = 32'h5be0cd19;
         default: h = 32'h6a09e667;
      endcase
      init_hash = h;
   endfunction

   // Round constants
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h428a2f98;
      endcase
      round_k = k;
   endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher_unit.sv
// SHA-256 hasher over a byte stream: block memory, round engine and digest output.
//
//   channel   direction  handshake                payload
//   req_      in         req_valid / req_ready    sha_req_type (byte, byte flag, end flag)
//   rsp_      out        rsp_valid / rsp_ready    sha_rsp_type (digest word, index, last)
//
// A byte that does not complete a block is taken while idle; the block memory holds bytes
// packed four to a word. A full block then passes a read-ahead state for the
// block memory, 64 rounds of the single round unit and a state that folds it into the hash.
// An end marker adds a setup state (ST_PAD) and one or two padding blocks, then
// eight digest transfers. req_ready is low from a full block or end marker until the
// round work (and the digest transfer) is done; rsp_ready low holds the current word.
// Reset restores the initial hash values and clears the byte and bit counts.
module sha256_byte_stream_hasher_unit
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sha_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sha_rsp_type rsp_payload
);

   // Control and datapath registers
   sha_state_type state_ff, state_in;
   sha_mode_type  mode_ff, mode_in;
   logic          fin_ff, fin_in;
   logic [5:0]    fill_ff, fill_in;
   logic [23:0]   acc_ff, acc_in;
   logic [63:0]   bits_ff, bits_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   logic [31:0]   hash_ff  [HASH_WORDS];
   logic [31:0]   hash_in  [HASH_WORDS];
   logic [31:0]   wv_ff    [HASH_WORDS];
   logic [31:0]   wv_in    [HASH_WORDS];
   logic [31:0]   sched_ff [BLOCK_WORDS];
   logic [31:0]   sched_in [BLOCK_WORDS];

   // Block memory, one 32-bit word per four bytes
   logic [31:0]   blk_mem [BLOCK_WORDS];
   logic [31:0]   rd_q_ff;
   logic [3:0]    rd_addr;
   logic          wr_en;
   logic [3:0]    wr_addr;
   logic [31:0]   wr_data;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          byte_take;
   logic          block_full;

   logic [3:0]    pw;
   logic [31:0]   pad_word;
   logic [31:0]   w_src;
   logic [31:0]   w_t;
   logic [31:0]   t1;
   logic [31:0]   t2;
   logic [31:0]   ch;
   logic [31:0]   maj;

   assign req_xfer   = req_valid & req_ready;
   assign rsp_xfer   = rsp_valid & rsp_ready;
   assign byte_take  = req_xfer & req_payload.byte_valid;
   assign block_full = byte_take & (fill_ff == 6'd63);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (block_full) begin
               state_in = ST_LOAD;
            end else if (req_xfer && req_payload.end_of_message) begin
               state_in = ST_PAD;
            end
         end
         ST_PAD:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_COMP;
         ST_COMP: begin
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            unique case (mode_ff)
               BLK_NORMAL:   state_in = fin_ff ? ST_PAD : ST_IDLE;
               BLK_PAD_ONLY: state_in = ST_LOAD;
               BLK_PAD_LEN,
               BLK_LEN_ONLY: state_in = ST_OUT;
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (rsp_xfer && idx_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs and memory read address
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rd_addr   = rnd_ff[3:0] + 4'd1;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_LOAD: rd_addr   = 4'd0;
         ST_OUT:  rsp_valid = 1'b1;
         ST_PAD, ST_COMP, ST_ADD: ;
         default: ;
      endcase
   end

   assign rsp_payload.digest_word = hash_ff[idx_ff];
   assign rsp_payload.word_index  = idx_ff;
   assign rsp_payload.last_word   = (idx_ff == 3'd7);

   // Byte packing into the block memory
   assign wr_en   = byte_take & (fill_ff[1:0] == 2'd3);
   assign wr_addr = fill_ff[5:2];
   assign wr_data = {acc_ff, req_payload.data_byte};

   // Partial word with the pad byte placed after the held bytes
   assign pw = fill_ff[5:2];
   always_comb begin
      unique case (fill_ff[1:0])
         2'd0: pad_word = {PAD_BYTE, 24'h0};
         2'd1: pad_word = {acc_ff[7:0], PAD_BYTE, 16'h0};
         2'd2: pad_word = {acc_ff[15:0], PAD_BYTE, 8'h0};
         2'd3: pad_word = {acc_ff[23:0], PAD_BYTE};
         default: pad_word = {PAD_BYTE, 24'h0};
      endcase
   end

   // Schedule word source for the first sixteen rounds
   always_comb begin
      w_src = 32'h0;
      unique case (mode_ff)
         BLK_NORMAL: w_src = rd_q_ff;
         BLK_PAD_LEN: begin
            priority if (rnd_ff[3:0] < pw) w_src = rd_q_ff;
            else if (rnd_ff[3:0] == pw)    w_src = pad_word;
            else if (rnd_ff[3:0] == 4'd14) w_src = bits_ff[63:32];
            else if (rnd_ff[3:0] == 4'd15) w_src = bits_ff[31:0];
            else                           w_src = 32'h0;
         end
         BLK_PAD_ONLY: begin
            priority if (rnd_ff[3:0] < pw) w_src = rd_q_ff;
            else if (rnd_ff[3:0] == pw)    w_src = pad_word;
            else                           w_src = 32'h0;
         end
         BLK_LEN_ONLY: begin
            priority if (rnd_ff[3:0] == 4'd14) w_src = bits_ff[63:32];
            else if (rnd_ff[3:0] == 4'd15)     w_src = bits_ff[31:0];
            else                               w_src = 32'h0;
         end
         default: w_src = 32'h0;
      endcase
   end

   // One compression round
   always_comb begin
      if (rnd_ff < 6'd16) begin
         w_t = w_src;
      end else begin
         w_t = small_sigma1(sched_ff[14]) + sched_ff[9] + small_sigma0(sched_ff[1])
               + sched_ff[0];
      end
      ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1  = wv_ff[7] + big_sigma1(wv_ff[4]) + ch + round_k(rnd_ff) + w_t;
      t2  = big_sigma0(wv_ff[0]) + maj;
   end

   // Datapath next values
   always_comb begin
      mode_in = mode_ff;
      fin_in  = fin_ff;
      fill_in = fill_ff;
      acc_in  = acc_ff;
      bits_in = bits_ff;
      rnd_in  = rnd_ff;
      idx_in  = idx_ff;
      for (int i = 0; i < HASH_WORDS; i++) begin
         hash_in[i] = hash_ff[i];
         wv_in[i]   = wv_ff[i];
      end
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         sched_in[i] = sched_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (byte_take) begin
               acc_in  = {acc_ff[15:0], req_payload.data_byte};
               fill_in = fill_ff + 6'd1;
            end
            if (block_full) begin
               bits_in = bits_ff + BLOCK_BITS;
               mode_in = BLK_NORMAL;
               fin_in  = req_payload.end_of_message;
            end
         end
         ST_PAD: begin
            bits_in = bits_ff + {55'h0, fill_ff, 3'b000};
            mode_in = (fill_ff >= 6'(LEN_BYTE)) ? BLK_PAD_ONLY : BLK_PAD_LEN;
            fin_in  = 1'b0;
         end
         ST_LOAD: begin
            rnd_in = 6'd0;
            for (int i = 0; i < HASH_WORDS; i++) begin
               wv_in[i] = hash_ff[i];
            end
         end
         ST_COMP: begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[BLOCK_WORDS - 1] = w_t;
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            rnd_in   = rnd_ff + 6'd1;
         end
         ST_ADD: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + wv_ff[i];
            end
            if (mode_ff == BLK_PAD_ONLY) begin
               mode_in = BLK_LEN_ONLY;
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               // last word out: start the next message from scratch
               if (idx_ff == 3'd7) begin
                  for (int i = 0; i < HASH_WORDS; i++) begin
                     hash_in[i] = init_hash(3'(i));
                  end
                  bits_in = 64'h0;
                  fill_in = 6'd0;
                  mode_in = BLK_NORMAL;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= BLK_NORMAL;
         fin_ff   <= 1'b0;
         fill_ff  <= 6'd0;
         bits_ff  <= 64'h0;
         rnd_ff   <= 6'd0;
         idx_ff   <= 3'd0;
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= init_hash(3'(i));
         end
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         fin_ff   <= fin_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= hash_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      for (int i = 0; i < HASH_WORDS; i++) begin
         wv_ff[i] <= wv_in[i];
      end
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         sched_ff[i] <= sched_in[i];
      end
   end

   // Block memory: writes only while idle; the registered read runs always and feeds compression
   always_ff @(posedge clock) begin
      if (wr_en) begin
         blk_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= blk_mem[rd_addr];
   end

endmodule

FILE: tb/sha256_byte_stream_hasher_unit_tb.sv
// Self-checking testbench for the SHA-256 byte stream hasher: directed table, random messages.
module sha256_byte_stream_hasher_unit_tb
   import sha_pkg::*;
();

   localparam int unsigned RANDOM_ITEMS = 140;
   localparam int unsigned MIN_MESSAGES = 5;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 200;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // One directed row: the transfer, and a typed-in digest where it is well known
   typedef struct packed {
      sha_req_type  item;
      logic         known;
      logic [255:0] digest;
   } dir_row_type;

   localparam int unsigned DIR_COUNT = 16;
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},   // empty message right after reset
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'd0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'd0},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},     // last byte and end together
      '{'{8'ha5, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},   // flagged-off byte on the end marker
      '{'{8'hff, 1'b0, 1'b0}, 1'b0, 256'd0},         // ignored byte
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, 256'd0},
      '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'd0},
      '{'{8'h55, 1'b0, 1'b0}, 1'b0, 256'd0},
      '{'{8'haa, 1'b1, 1'b0}, 1'b0, 256'd0},
      '{'{8'h80, 1'b0, 1'b1}, 1'b0, 256'd0},         // end marker on its own
      '{'{8'hff, 1'b1, 1'b1}, 1'b0, 256'd0},         // one-byte messages
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'd0},
      '{'{8'h3c, 1'b0, 1'b0}, 1'b0, 256'd0},
      '{'{8'hc3, 1'b1, 1'b0}, 1'b0, 256'd0},
      '{'{8'h00, 1'b0, 1'b1}, 1'b0, 256'd0}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   sha_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   sha_rsp_type rsp_payload;

   sha256_byte_stream_hasher_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hash model state
   logic [31:0]  model_hash [8];
   logic [7:0]   model_block [64];
   int unsigned  model_fill;
   logic [63:0]  model_bits;
   logic [255:0] model_digest;

   sha_rsp_type  pending_digest_words [$];
   int unsigned  error_count   = 0;
   int unsigned  sent_count    = 0;
   int unsigned  send_idle_pct = 33;
   int unsigned  recv_idle_pct = 49;
   int unsigned  cycle_count   = 0;

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void model_clear();
      for (int i = 0; i < 8; i++)
         model_hash[i] = START_HASH[i];
      for (int i = 0; i < 64; i++)
         model_block[i] = 8'h00;
      model_fill = 0;
      model_bits = 64'd0;
   endfunction

   // 64-round compression of the current block into the hash words
   function automatic void model_compress();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < 16; i++)
         w[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2], model_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++)
         s[i] = model_hash[i];
      for (int r = 0; r < 64; r++) begin
         t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + ROUND_CONST[r] + w[r];
         t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6];
         s[6] = s[5];
         s[5] = s[4];
         s[4] = s[3] + t1;
         s[3] = s[2];
         s[2] = s[1];
         s[1] = s[0];
         s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         model_hash[i] = model_hash[i] + s[i];
   endfunction

   // Absorb one transfer; returns 1 when it finishes a message (digest in model_digest)
   function automatic bit model_step(input sha_req_type item);
      if (item.byte_valid) begin
         model_block[model_fill] = item.data_byte;
         model_fill = model_fill + 1;
         if (model_fill == BLOCK_BYTES) begin
            model_compress();
            model_bits = model_bits + BLOCK_BITS;
            model_fill = 0;
         end
      end
      if (!item.end_of_message)
         return 1'b0;

      // Padding, with an extra block when the length no longer fits
      model_bits = model_bits + 64'(model_fill) * 64'd8;
      model_block[model_fill] = PAD_BYTE;
      model_fill = model_fill + 1;
      if (model_fill > LEN_BYTE) begin
         while (model_fill < BLOCK_BYTES) begin
            model_block[model_fill] = 8'h00;
            model_fill = model_fill + 1;
         end
         model_compress();
         model_fill = 0;
      end
      while (model_fill < LEN_BYTE) begin
         model_block[model_fill] = 8'h00;
         model_fill = model_fill + 1;
      end
      for (int i = 0; i < 8; i++)
         model_block[LEN_BYTE + i] = model_bits[63 - 8*i -: 8];
      model_compress();
      for (int i = 0; i < 8; i++)
         model_digest[255 - 32*i -: 32] = model_hash[i];
      model_clear();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Present one transfer, wait for acceptance, then queue the digest it causes
   task automatic send_item(input sha_req_type item, input logic known,
                            input logic [255:0] known_digest);
      sha_rsp_type word;
      if (sent_count < 80) begin
         send_idle_pct = 33;
         recv_idle_pct = 49;
      end else if (sent_count < 160) begin
         send_idle_pct = 49;
         recv_idle_pct = 33;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent_count++;
      if (model_step(item)) begin
         for (int i = 0; i < 8; i++) begin
            word.digest_word = known ? known_digest[255 - 32*i -: 32]
                                     : model_digest[255 - 32*i -: 32];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            pending_digest_words.push_back(word);
         end
      end
   endtask

   // Receiver: random back-pressure and in-order digest check
   always @(posedge clock) begin
      sha_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_digest_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h index %0d",
                                         rsp_payload.digest_word, rsp_payload.word_index));
            end else begin
               want = pending_digest_words.pop_front();
               if (rsp_payload.digest_word !== want.digest_word)
                  report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                            rsp_payload.digest_word, want.digest_word,
                                            want.word_index));
               if (rsp_payload.word_index !== want.word_index)
                  report_mismatch($sformatf("word_index %0d, expected %0d",
                                            rsp_payload.word_index, want.word_index));
               if (rsp_payload.last_word !== want.last_word)
                  report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                            rsp_payload.last_word, want.last_word,
                                            want.word_index));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pending_digest_words.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      sha_req_type item;
      int unsigned rnd_items;
      int unsigned msg_count;
      int unsigned msg_len;
      bit          end_with_byte;

      model_clear();
      rnd_items = 0;
      msg_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int r = 0; r < DIR_COUNT; r++)
         send_item(DIR_ROWS[r].item, DIR_ROWS[r].known, DIR_ROWS[r].digest);

      // Hold off until every queued digest word has drained
      req_valid <= 1'b0;
      while (pending_digest_words.size() != 0)
         @(posedge clock);

      // Random messages; one needs the extra padding block, one fills a whole block
      while (rnd_items < RANDOM_ITEMS || msg_count < MIN_MESSAGES) begin
         case (msg_count)
            1:       msg_len = LEN_BYTE;
            3:       msg_len = BLOCK_BYTES;
            default: msg_len = $urandom_range(12);
         endcase
         end_with_byte = (msg_len != 0) && ($urandom_range(1) == 1);
         for (int i = 0; i < msg_len; i++) begin
            if ($urandom_range(9) == 0) begin
               item.data_byte      = 8'($urandom_range(255));
               item.byte_valid     = 1'b0;
               item.end_of_message = 1'b0;
               send_item(item, 1'b0, 256'd0);
            end
            item.data_byte      = 8'($urandom_range(255));
            item.byte_valid     = 1'b1;
            item.end_of_message = end_with_byte && (i == msg_len - 1);
            send_item(item, 1'b0, 256'd0);
            rnd_items++;
         end
         if (!end_with_byte) begin
            item.data_byte      = 8'($urandom_range(255));
            item.byte_valid     = 1'b0;
            item.end_of_message = 1'b1;
            send_item(item, 1'b0, 256'd0);
            rnd_items++;
         end
         msg_count++;
      end

      // Drain and watch for stray words
      req_valid <= 1'b0;
      while (pending_digest_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
